@@ src/tbrl_pkg.sv @@
// ---------------------------------------------------------------------------
// Token bucket rate limiter package
// Shared types and constants for the controller, the datapath and the top.
// ---------------------------------------------------------------------------
package tbrl_pkg;

  localparam int TIME_BITS_DEF = 48;
  localparam int FRAC_BITS_DEF = 24;

  localparam int TOK_W  = 16;
  localparam int RATE_W = 32;
  localparam int RETRY_W = 32;

  // Result beat: allowed, never_refills, retry_ms, tokens_whole.
  localparam int RES_W = 1 + 1 + RETRY_W + TOK_W;
  localparam int OUT_W = ((RES_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_REFILL   = CFG_IDX_W'(1);

  localparam logic [TOK_W-1:0]  CAPACITY_RESET = TOK_W'(16);
  localparam logic [RATE_W-1:0] REFILL_RESET   = RATE_W'(16777216);

  typedef struct packed {
    logic load;
    logic set_zero;
    logic mul_step;
    logic refill;
    logic decide;
    logic div_step;
    logic div_fin;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic req_zero;
    logic later;
    logic need_div;
  } status_t;

endpackage

@@ src/tbrl_ctrl.sv @@
// ---------------------------------------------------------------------------
// Token bucket rate limiter controller
// Sequences load, refill multiply, decision, retry division and result beat.
// ---------------------------------------------------------------------------
module tbrl_ctrl #(
  parameter int TIME_BITS = tbrl_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = tbrl_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  tbrl_pkg::status_t st,
  output tbrl_pkg::cmd_t    cmd
);
  import tbrl_pkg::*;

  localparam int LVL_W  = TOK_W + FRAC_BITS;
  localparam int STEP_MAX = (TIME_BITS > LVL_W) ? TIME_BITS : LVL_W;
  localparam int CNT_W  = $clog2(STEP_MAX);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]       state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             m_tvalid_next;
  logic             accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.req_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = S_DONE;
        end else if (st.later) begin
          cnt_next   = CNT_W'(TIME_BITS - 1);
          state_next = S_MUL;
        end else begin
          state_next = S_UPD;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_UPD;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_UPD: begin
        cmd.refill = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (st.need_div) begin
          cnt_next   = CNT_W'(LVL_W - 1);
          state_next = S_DIV;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == '0) begin
          state_next = S_FIN;
        end else begin
          cnt_next = cnt - 1'b1;
        end
      end
      S_FIN: begin
        cmd.div_fin = 1'b1;
        state_next  = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(m_tvalid && !m_tready))
    else $error("result register overwritten");

  // Only one request is in flight.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("second request accepted while busy");

  // A zero request never takes the division path.
  a_zero_no_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> !st.req_zero)
    else $error("zero request reached the divider");

endmodule

@@ src/tbrl_dp.sv @@
// ---------------------------------------------------------------------------
// Token bucket rate limiter datapath
// Bucket state, serial refill multiplier, restoring divider and result beat.
// ---------------------------------------------------------------------------
module tbrl_dp #(
  parameter int TIME_BITS = tbrl_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = tbrl_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [TIME_BITS-1:0]             now_ms,
  input  logic [tbrl_pkg::TOK_W-1:0]       req_tokens,
  input  logic                             cfg_write,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tbrl_pkg::RATE_W-1:0]      cfg_data,
  input  tbrl_pkg::cmd_t                   cmd,
  output tbrl_pkg::status_t                st,
  output logic [tbrl_pkg::OUT_W-1:0]       result
);
  import tbrl_pkg::*;

  localparam int LVL_W = TOK_W + FRAC_BITS;
  localparam int SUM_W = ((LVL_W + 1 > RATE_W) ? LVL_W + 1 : RATE_W) + 1;
  localparam int Q_W   = (LVL_W + 1 > RETRY_W + 1) ? LVL_W + 1 : RETRY_W + 1;

  logic [TOK_W-1:0]     capacity;
  logic [RATE_W-1:0]    refill_per_ms;
  logic [LVL_W-1:0]     level;
  logic [TIME_BITS-1:0] last_time;
  logic [TIME_BITS-1:0] now_q;
  logic [TOK_W-1:0]     req_q;
  logic [TIME_BITS-1:0] elapsed;
  logic [LVL_W-1:0]     acc;
  logic                 sat;
  logic                 later;
  logic [LVL_W-1:0]     quo;
  logic [RATE_W-1:0]    rem;
  logic                 res_allowed;
  logic                 res_never;
  logic [RETRY_W-1:0]   res_retry;

  logic [LVL_W-1:0]  cap_fix;
  logic [LVL_W-1:0]  need;
  logic [LVL_W:0]    refill_sum;
  logic [SUM_W-1:0]  mul_sum;
  logic [RATE_W:0]   rem_sh;
  logic              rem_ge;
  logic [Q_W-1:0]    q_up;
  logic              enough;

  assign cap_fix = ((capacity == '0) ? LVL_W'(1) : LVL_W'(capacity)) << FRAC_BITS;
  assign need    = LVL_W'(req_q) << FRAC_BITS;
  assign enough  = (level >= need);

  // Horner step over the elapsed time, most significant bit first.
  assign mul_sum = SUM_W'({acc, 1'b0})
                 + (elapsed[TIME_BITS-1] ? SUM_W'(refill_per_ms) : SUM_W'(0));
  assign refill_sum = (LVL_W + 1)'(level) + (LVL_W + 1)'(acc);

  assign rem_sh = {rem, quo[LVL_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, refill_per_ms});
  assign q_up   = Q_W'(quo) + Q_W'(rem != '0);

  assign st.req_zero = (req_q == '0);
  assign st.later    = later;
  assign st.need_div = !enough && (refill_per_ms != '0);

  // Configuration registers and bucket state.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity      <= CAPACITY_RESET;
      refill_per_ms <= REFILL_RESET;
      level         <= LVL_W'(CAPACITY_RESET) << FRAC_BITS;
      last_time     <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CAPACITY: capacity      <= cfg_data[TOK_W-1:0];
          REG_REFILL:   refill_per_ms <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.refill && later) begin
        if (sat || refill_sum >= (LVL_W + 1)'(cap_fix)) begin
          level <= cap_fix;
        end else begin
          level <= refill_sum[LVL_W-1:0];
        end
        last_time <= now_q;
      end
      if (cmd.decide && enough) begin
        level <= level - need;
      end
    end
  end

  // Working registers; no reset needed.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_q   <= now_ms;
      req_q   <= req_tokens;
      later   <= (now_ms > last_time);
      elapsed <= now_ms - last_time;
      acc     <= '0;
      sat     <= 1'b0;
    end
    if (cmd.mul_step) begin
      acc     <= mul_sum[LVL_W-1:0];
      sat     <= sat || (mul_sum[SUM_W-1:LVL_W] != '0);
      elapsed <= elapsed << 1;
    end
    if (cmd.set_zero) begin
      res_allowed <= 1'b1;
      res_never   <= 1'b0;
      res_retry   <= '0;
    end
    if (cmd.decide) begin
      res_allowed <= enough;
      res_never   <= !enough && (refill_per_ms == '0);
      res_retry   <= '0;
      quo         <= need - level;
      rem         <= '0;
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= RATE_W'(rem_sh - {1'b0, refill_per_ms});
      end else begin
        rem <= rem_sh[RATE_W-1:0];
      end
      quo <= {quo[LVL_W-2:0], rem_ge};
    end
    if (cmd.div_fin) begin
      if (q_up[Q_W-1:RETRY_W] != '0) begin
        res_retry <= '1;
      end else begin
        res_retry <= q_up[RETRY_W-1:0];
      end
    end
    if (cmd.emit) begin
      result <= OUT_W'({level[LVL_W-1 -: TOK_W], res_retry, res_never, res_allowed});
    end
  end

  // The remainder of a finished division is below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.div_fin |-> (rem < refill_per_ms))
    else $error("divider remainder out of range");

  // A refill with a later timestamp never leaves the level above capacity.
  a_refill_cap: assert property (@(posedge clk) disable iff (rst)
    (cmd.refill && later) |=> (level <= $past(cap_fix)))
    else $error("refill exceeded capacity");

endmodule

@@ src/token_bucket_rate_limiter_unit.sv @@
// ---------------------------------------------------------------------------
// Token bucket rate limiter unit
// Grants or refuses timestamped token requests against a refilling bucket.
// ---------------------------------------------------------------------------
// One request is handled at a time. A zero-token request goes straight to its
// result beat. Any other request runs a bit-serial refill multiply, one step
// per timestamp bit, when its timestamp is later than the stored one. A refused
// request with a nonzero rate then runs a restoring divider, one step per level
// bit (16 + FRAC_BITS bits), for the retry time. The result sits in an output
// register, so a new request is accepted while the previous result waits to be
// taken. The configuration port is always ready; it is to be written only while
// idle, which the unit itself does not enforce.
module token_bucket_rate_limiter_unit #(
  parameter int TIME_BITS = tbrl_pkg::TIME_BITS_DEF,
  parameter int FRAC_BITS = tbrl_pkg::FRAC_BITS_DEF,
  localparam int IN_W = ((TIME_BITS + tbrl_pkg::TOK_W + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // now_ms, req_tokens
  input  logic [IN_W-1:0]                s_tdata,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // allowed, never_refills, retry_ms, tokens_whole
  output logic [tbrl_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbrl_pkg::RATE_W-1:0]    cfg_data
);
  import tbrl_pkg::*;

  cmd_t    cmd;
  status_t st;

  assign cfg_ready = 1'b1;

  tbrl_ctrl #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tbrl_dp #(
    .TIME_BITS (TIME_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .now_ms     (s_tdata[TIME_BITS-1:0]),
    .req_tokens (s_tdata[TIME_BITS +: TOK_W]),
    .cfg_write  (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .st         (st),
    .result     (m_tdata)
  );

endmodule

@@ tb/tbrl_grant_checker.sv @@
// ---------------------------------------------------------------------------
// Token bucket grant checker
// Watches the request, result and register channels of the rate limiter,
// keeps its own copy of the bucket and compares every result beat in order.
// ---------------------------------------------------------------------------
module tbrl_grant_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  // now_ms, req_tokens
  input  logic [63:0]                    s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  // allowed, never_refills, retry_ms, tokens_whole
  input  logic [tbrl_pkg::OUT_W-1:0]     m_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tbrl_pkg::RATE_W-1:0]    cfg_data,
  output int                             pending,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tbrl_pkg::*;

  localparam int STAMP_W = TIME_BITS_DEF;
  localparam int FRAC    = FRAC_BITS_DEF;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic               allowed;
    logic               never_refills;
    logic [RETRY_W-1:0] retry_ms;
    logic [TOK_W-1:0]   tokens_whole;
  } grant_t;

  logic [TOK_W-1:0]   cap_reg;
  logic [RATE_W-1:0]  rate_reg;
  logic [63:0]        bucket_level;
  logic [STAMP_W-1:0] stamp_ms;
  grant_t             grant_q[$];

  function automatic logic [63:0] cap_fixed();
    return 64'(cap_reg == '0 ? TOK_W'(1) : cap_reg) << FRAC;
  endfunction

  // Refill, then grant or refuse one request; updates the bucket copy.
  function automatic grant_t decide_request(input logic [STAMP_W-1:0] stamp,
                                            input logic [TOK_W-1:0] req);
    grant_t      g;
    logic [63:0] cap_fx, need, missing, quot;
    logic [95:0] gain;
    g = '{allowed: 1'b1, never_refills: 1'b0, retry_ms: '0, tokens_whole: '0};
    if (req != '0) begin
      cap_fx = cap_fixed();
      if (stamp > stamp_ms) begin
        gain = 96'(stamp - stamp_ms) * 96'(rate_reg);
        if (bucket_level >= cap_fx || gain >= 96'(cap_fx - bucket_level)) begin
          bucket_level = cap_fx;
        end else begin
          bucket_level = bucket_level + gain[63:0];
        end
        stamp_ms = stamp;
      end
      need = 64'(req) << FRAC;
      if (bucket_level >= need) begin
        bucket_level = bucket_level - need;
      end else begin
        missing = need - bucket_level;
        g.allowed = 1'b0;
        if (rate_reg == '0) begin
          g.never_refills = 1'b1;
        end else begin
          quot = (missing + 64'(rate_reg) - 64'd1) / 64'(rate_reg);
          g.retry_ms = (quot > 64'hFFFF_FFFF) ? '1 : quot[RETRY_W-1:0];
        end
      end
    end
    g.tokens_whole = TOK_W'(bucket_level >> FRAC);
    return g;
  endfunction

  initial fail_count = 0;
  initial pending = 0;

  always @(posedge clk) begin
    grant_t seen, want;
    if (rst) begin
      cap_reg      = CAPACITY_RESET;
      rate_reg     = REFILL_RESET;
      bucket_level = cap_fixed();
      stamp_ms     = '0;
      grant_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CAPACITY: cap_reg = cfg_data[TOK_W-1:0];
          REG_REFILL:   rate_reg = cfg_data;
          default: ;
        endcase
      end
      // Compare the result beat before predicting a request taken at the
      // same edge, which can only belong to a later result.
      if (m_tvalid && m_tready) begin
        seen = m_tdata[$bits(grant_t)-1:0];
        seen = '{allowed: m_tdata[0], never_refills: m_tdata[1],
                 retry_ms: m_tdata[2 +: RETRY_W],
                 tokens_whole: m_tdata[2 + RETRY_W +: TOK_W]};
        if (grant_q.size() == 0) begin
          if (fail_count < REPORT_LIMIT) begin
            $display("%t: unexpected beat: allowed=%0d never=%0d retry=%0d tokens=%0d",
                     $realtime, seen.allowed, seen.never_refills, seen.retry_ms,
                     seen.tokens_whole);
          end
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (seen.allowed !== want.allowed || seen.never_refills !== want.never_refills ||
              seen.retry_ms !== want.retry_ms || seen.tokens_whole !== want.tokens_whole) begin
            if (fail_count < REPORT_LIMIT) begin
              $display("%t: expected allowed=%0d never=%0d retry=%0d tokens=%0d",
                       $realtime, want.allowed, want.never_refills, want.retry_ms,
                       want.tokens_whole);
              $display("%t: actual   allowed=%0d never=%0d retry=%0d tokens=%0d",
                       $realtime, seen.allowed, seen.never_refills, seen.retry_ms,
                       seen.tokens_whole);
            end
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        grant_q.push_back(decide_request(s_tdata[STAMP_W-1:0], s_tdata[STAMP_W +: TOK_W]));
      end
    end
    pending <= grant_q.size();
  end

endmodule

@@ tb/token_bucket_rate_limiter_unit_tb.sv @@
// ---------------------------------------------------------------------------
// Token bucket rate limiter testbench
// Drives timestamped token requests and register writes into the unit under
// random backpressure; a checker beside the unit predicts every result beat.
// ---------------------------------------------------------------------------
module token_bucket_rate_limiter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbrl_pkg::*;

  localparam int STAMP_W = TIME_BITS_DEF;
  localparam int IN_W = ((STAMP_W + TOK_W + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 200;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_REFILL + CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
  localparam logic [RATE_W-1:0] ONE_TOKEN = RATE_W'(1) << FRAC_BITS_DEF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_W-1:0]      m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [RATE_W-1:0]     cfg_data = '0;

  int                    pending;
  int                    fail_count;
  int                    stall_cycles = 0;
  logic                  rx_hold = 1'b0;
  logic                  rx_quiet = 1'b0;
  bit                    tx_quiet = 1'b0;
  logic [STAMP_W-1:0]    cur_ms = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  token_bucket_rate_limiter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  tbrl_grant_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    m_tready <= !rx_hold && (rx_quiet || $urandom_range(99) >= 23);
  end

  // Ends a run that has stopped moving on every channel.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Leaves tvalid high so that back-to-back requests need no extra edge.
  task automatic push_request(input logic [STAMP_W-1:0] stamp, input logic [TOK_W-1:0] req);
    s_tdata  <= IN_W'({req, stamp});
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause_tx();
    int n;
    n = 0;
    if (!tx_quiet && $urandom_range(99) < 23) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(10, 120) : $urandom_range(1, 4);
    end
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_bucket(input logic [RATE_W-1:0] cap, input logic [RATE_W-1:0] rate);
    drain_results();
    write_reg(REG_CAPACITY, cap);
    write_reg(REG_REFILL, rate);
    cfg_valid <= 1'b0;
  endtask

  // Timestamps mostly creep forward; some repeat, go backward or jump ahead.
  function automatic logic [STAMP_W-1:0] next_stamp();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      cur_ms = cur_ms + STAMP_W'($urandom_range(0, 8));
    end else if (pick < 75) begin
      return cur_ms;
    end else if (pick < 85) begin
      return (cur_ms > 1000) ? cur_ms - STAMP_W'($urandom_range(1, 1000)) : '0;
    end else if (pick < 95) begin
      cur_ms = cur_ms + STAMP_W'($urandom_range(0, 2000));
    end else begin
      cur_ms = cur_ms + STAMP_W'($urandom);
    end
    return cur_ms;
  endfunction

  function automatic logic [TOK_W-1:0] pick_tokens(input int tok_max);
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) return '0;
    if (pick < 15) return '1;
    if (pick < 20) return TOK_W'($urandom_range(0, 65535));
    return TOK_W'($urandom_range(1, tok_max));
  endfunction

  task automatic run_random(input int count, input int tok_max);
    repeat (count) begin
      pause_tx();
      push_request(next_stamp(), pick_tokens(tok_max));
    end
  endtask

  initial begin
    logic [RATE_W-1:0] cap, rate;
    logic [STAMP_W-1:0] stamp;
    int tok_max;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: capacity 16, one token per millisecond.
    push_request('0, '0);
    push_request('0, TOK_W'(16));
    push_request('0, TOK_W'(1));
    push_request(STAMP_W'(5), '0);
    push_request(STAMP_W'(5), TOK_W'(3));
    push_request(STAMP_W'(3), TOK_W'(1));
    push_request(STAMP_W'(1000), '1);
    push_request(STAMP_W'(1000), TOK_W'(16));
    cur_ms = STAMP_W'(1000);

    // Widest bucket and fastest rate; a huge gap saturates the refill.
    set_bucket(RATE_W'(65535), '1);
    cur_ms = cur_ms + (STAMP_W'(1) << 40);
    push_request(cur_ms, '1);
    push_request(cur_ms, TOK_W'(1));
    run_random(150, 65535);

    // Zero capacity acts as one token, and a zero rate never refills.
    set_bucket('0, '0);
    cur_ms = cur_ms + STAMP_W'(10);
    push_request(cur_ms, TOK_W'(1));
    push_request(cur_ms, TOK_W'(2));
    run_random(60, 3);

    // Slowest nonzero rate: long waits saturate the retry time.
    set_bucket(RATE_W'(1000), RATE_W'(1));
    push_request(cur_ms, '1);
    run_random(100, 1200);

    // Lowering the capacity leaves the level until a later refill.
    set_bucket(RATE_W'(40000), ONE_TOKEN << 4);
    cur_ms = cur_ms + STAMP_W'(5000);
    push_request(cur_ms, TOK_W'(1));
    drain_results();
    write_reg(REG_SPARE_LO, RATE_W'(3));
    write_reg(REG_SPARE_HI, '1);
    write_reg(REG_CAPACITY, RATE_W'(8));
    cfg_valid <= 1'b0;
    push_request(cur_ms, TOK_W'(2));
    push_request(cur_ms + STAMP_W'(1), TOK_W'(2));
    run_random(40, 12);

    for (int phase = 0; phase < 4; phase++) begin
      cap = ($urandom_range(3) == 0) ? RATE_W'($urandom_range(1, 65535))
                                     : RATE_W'($urandom_range(1, 200));
      rate = $urandom >> $urandom_range(0, 31);
      tok_max = (cap + cap / 4 + 1 > 65535) ? 65535 : int'(cap + cap / 4 + 1);
      set_bucket(cap, rate);
      if (phase == 1) begin
        tx_quiet = 1'b1;
        rx_quiet <= 1'b1;
        run_random(100, tok_max);
        tx_quiet = 1'b0;
        rx_quiet <= 1'b0;
      end else if (phase == 2) begin
        // The receiver stalls while requests keep coming, so the unit backs up.
        fork
          begin
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
          end
          run_random(100, tok_max);
        join
      end else begin
        run_random(100, tok_max);
      end
    end

    // Full-range timestamps last, since the stored one can only grow.
    set_bucket(RATE_W'(65535), $urandom);
    push_request(STAMP_MAX - STAMP_W'(1), '1);
    repeat (80) begin
      pause_tx();
      stamp = ($urandom_range(7) == 0) ? STAMP_MAX : STAMP_W'({$urandom, $urandom});
      push_request(stamp, pick_tokens(65535));
    end
    push_request(STAMP_MAX, '1);

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ token_bucket_rate_limiter_unit.f @@
src/tbrl_pkg.sv
src/tbrl_ctrl.sv
src/tbrl_dp.sv
src/token_bucket_rate_limiter_unit.sv
tb/tbrl_grant_checker.sv
tb/token_bucket_rate_limiter_unit_tb.sv
